@@ src/urdfp_pkg.sv @@
// Shared types and constants for the serial digit frame parser.
package urdfp_pkg;

    // Widths of the timing registers and of the received byte
    localparam int TIMER_W = 16;
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 10;
    localparam int BITIDX_W = 4;
    localparam int SLOT_W  = 3;
    localparam int PTR_W   = 4;
    localparam int DIGIT_W = 4;

    // Packed result width and its byte-padded stream width
    localparam int RESULT_W = BYTE_W + 1 + 1 + SLOT_W + DIGIT_W + 1;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Bit count at which the stop bit has been taken
    localparam logic [BITIDX_W-1:0] LAST_BIT_IDX = BITIDX_W'(FRAME_W - 1);

    // Reset values of the timing registers
    localparam logic [TIMER_W-1:0] BIT_PERIOD_RST  = 16'd104;
    localparam logic [TIMER_W-1:0] FIRST_DELAY_RST = 16'd52;

    // Configuration register indexes
    localparam logic CFG_BIT_PERIOD  = 1'b0;
    localparam logic CFG_FIRST_DELAY = 1'b1;

    // Parser characters
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2c;
    localparam logic [BYTE_W-1:0] CHR_CLOSE  = 8'h7d;
    localparam logic [BYTE_W-1:0] CHR_OPEN   = 8'h7b;

    // A byte leaving the bit receiver on the stop bit sample
    typedef struct packed {
        logic              done;
        logic              good;
        logic [BYTE_W-1:0] data;
    } t_rx_byte;

    // One result item
    typedef struct packed {
        logic               frame_open;
        logic [DIGIT_W-1:0] digit_value;
        logic [SLOT_W-1:0]  slot_written;
        logic               digit_stored;
        logic               framing_error;
        logic [BYTE_W-1:0]  byte_value;
    } t_result;

endpackage

@@ src/urdfp_bit_rx.sv @@
// Serial bit timing and byte assembly for one line sample per step.
module urdfp_bit_rx (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_level,
    input  logic [urdfp_pkg::TIMER_W-1:0]  i_bit_period,
    input  logic [urdfp_pkg::TIMER_W-1:0]  i_first_delay,
    output urdfp_pkg::t_rx_byte            o_byte
);
    import urdfp_pkg::*;

    logic                 r_line_prev;
    logic                 r_receiving;
    logic [TIMER_W-1:0]   r_phase;
    logic [BITIDX_W-1:0]  r_bit_idx;
    logic [FRAME_W-1:0]   r_shift;

    logic                 sample_now;
    logic                 last_bit;
    logic [FRAME_W-1:0]   n_shift;

    // A bit is sampled when the phase counter runs out
    assign sample_now = r_receiving && (r_phase <= TIMER_W'(1));
    assign last_bit   = (r_bit_idx == LAST_BIT_IDX);
    assign n_shift    = {i_level, r_shift[FRAME_W-1:1]};

    // The byte is complete on the stop bit sample
    assign o_byte.done = i_en && sample_now && last_bit;
    assign o_byte.good = n_shift[FRAME_W-1] && !n_shift[0];
    assign o_byte.data = n_shift[BYTE_W:1];

    // Start edge detection, bit timing and the shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_prev <= 1'b1;
            r_receiving <= 1'b0;
            r_phase     <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
        end else if (i_en) begin
            r_line_prev <= i_level;
            if (!r_receiving) begin
                if (r_line_prev && !i_level) begin
                    r_receiving <= 1'b1;
                    r_phase     <= i_first_delay;
                    r_bit_idx   <= '0;
                    r_shift     <= '0;
                end
            end else if (!sample_now) begin
                r_phase <= r_phase - TIMER_W'(1);
            end else begin
                r_shift <= n_shift;
                if (last_bit) begin
                    r_receiving <= 1'b0;
                    r_bit_idx   <= '0;
                    r_phase     <= '0;
                end else begin
                    r_bit_idx <= r_bit_idx + BITIDX_W'(1);
                    r_phase   <= i_bit_period;
                end
            end
        end
    end

endmodule

@@ src/urdfp_parser.sv @@
// Brace and comma frame parser that places digits into numbered slots.
module urdfp_parser #(
    parameter int TEXT_SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  urdfp_pkg::t_rx_byte  i_byte,
    output urdfp_pkg::t_result   o_result
);
    import urdfp_pkg::*;

    // The slot pointer stops at the slot count, but never above 15
    localparam int SLOT_LIMIT = (TEXT_SLOTS > 15) ? 15 : TEXT_SLOTS;

    logic              r_in_frame;
    logic [PTR_W-1:0]  r_slot_ptr;
    logic              n_in_frame;
    logic [PTR_W-1:0]  n_slot_ptr;

    logic              is_digit;
    logic              stored;
    logic [BYTE_W-1:0] digit_full;

    assign is_digit   = (i_byte.data >= CHR_ZERO) && (i_byte.data <= CHR_NINE);
    assign digit_full = i_byte.data - CHR_ZERO;

    // A digit is stored only inside a frame and while slots remain
    assign stored = i_byte.done && i_byte.good && r_in_frame && is_digit
                    && ({1'b0, r_slot_ptr} < 5'(TEXT_SLOTS));

    // Next frame state for a well-formed byte
    always_comb begin
        n_in_frame = r_in_frame;
        n_slot_ptr = r_slot_ptr;
        if (i_byte.done && i_byte.good) begin
            if (r_in_frame) begin
                if (i_byte.data == CHR_COMMA) begin
                    if ({1'b0, r_slot_ptr} < 5'(SLOT_LIMIT)) begin
                        n_slot_ptr = r_slot_ptr + PTR_W'(1);
                    end
                end else if (i_byte.data == CHR_CLOSE) begin
                    n_in_frame = 1'b0;
                end
            end else if (i_byte.data == CHR_OPEN) begin
                n_slot_ptr = '0;
                n_in_frame = 1'b1;
            end
        end
    end

    // Result fields for this byte
    assign o_result.byte_value    = i_byte.data;
    assign o_result.framing_error = !i_byte.good;
    assign o_result.digit_stored  = stored;
    assign o_result.slot_written  = stored ? r_slot_ptr[SLOT_W-1:0] : '0;
    assign o_result.digit_value   = stored ? digit_full[DIGIT_W-1:0] : '0;
    assign o_result.frame_open    = n_in_frame;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_slot_ptr <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_slot_ptr <= n_slot_ptr;
        end
    end

endmodule

@@ src/uart_rx_digit_frame_parser.sv @@
// Top level of the serial receiver with the digit frame parser.
//
// The slave stream carries one sample of the serial line per request
// (tdata bit 0, idle high). Every request is one clock of line time, so
// the bit timing counts requests, not clock edges. The master stream gives
// one result per received byte, on the request that samples the stop bit.
// A sample passes an input register and a single pass of bit timing and
// parsing logic into the result register. One sample is taken every
// cycle while the result side keeps up. When a result waits untaken,
// the input register and then tready hold; samples are never dropped.
// The config port sets bit_period (index 0) and first_sample_delay (index
// 1); a value of 0 acts as 1. Write them only while the line is idle.
// Reset restores both to 104 and 52, clears the receiver and closes any
// open frame. Framing errors are reported with the data bits and leave the
// parser untouched.
module uart_rx_digit_frame_parser #(
    parameter int TEXT_SLOTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Line samples
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [0] rx_level
    // Results
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] byte_value, [8] framing_error, [9] digit_stored,
    // [12:10] slot_written, [16:13] digit_value, [17] frame_open
    output logic [urdfp_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [urdfp_pkg::TIMER_W-1:0]   i_cfg_wdata
);
    import urdfp_pkg::*;

    logic [TIMER_W-1:0] r_bit_period;
    logic [TIMER_W-1:0] r_first_delay;

    logic               r_in_valid;
    logic               r_in_level;
    logic               r_out_valid;
    t_result            r_out;

    logic               advance;
    logic               step;
    t_rx_byte           rx_byte;
    t_result            result;

    // The pipeline moves when the result register is free or being taken
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = advance && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= BIT_PERIOD_RST;
            r_first_delay <= FIRST_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIT_PERIOD:  r_bit_period  <= i_cfg_wdata;
                CFG_FIRST_DELAY: r_first_delay <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_level <= i_s_axis_tdata[0];
        end
    end

    urdfp_bit_rx u_bit_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (step),
        .i_level       (r_in_level),
        .i_bit_period  (r_bit_period),
        .i_first_delay (r_first_delay),
        .o_byte        (rx_byte)
    );

    urdfp_parser #(
        .TEXT_SLOTS (TEXT_SLOTS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (rx_byte),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= rx_byte.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_byte.done) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out);

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the serial digit frame parser: line-level stimulus, sample-by-sample prediction.
`timescale 1ns / 100ps

module tb;
    import urdfp_pkg::*;

    localparam int TEXT_SLOTS = 8;
    localparam int SLOT_CAP   = (TEXT_SLOTS > 15) ? 15 : TEXT_SLOTS;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = 8'h01;  // [0] rx_level
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [7:0] byte_value, [8] framing_error, [9] digit_stored,
    // [12:10] slot_written, [16:13] digit_value, [17] frame_open
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = CFG_BIT_PERIOD;
    logic [TIMER_W-1:0]   i_cfg_wdata = '0;

    uart_rx_digit_frame_parser #(.TEXT_SLOTS(TEXT_SLOTS)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    // Line samples waiting to be sent, and results still owed by the block.
    logic    line_queue[$];
    t_result expected_bytes[$];
    logic    line_taken = 1'b0;
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      gen_period = BIT_PERIOD_RST;
    int      gen_delay = FIRST_DELAY_RST;

    // Predictor state: timing registers, bit receiver and parser.
    logic [TIMER_W-1:0]  bit_period_reg = BIT_PERIOD_RST;
    logic [TIMER_W-1:0]  first_delay_reg = FIRST_DELAY_RST;
    logic                line_prev = 1'b1;
    logic                rx_active = 1'b0;
    logic [TIMER_W-1:0]  phase_count = '0;
    logic [BITIDX_W-1:0] bit_count = '0;
    logic [FRAME_W-1:0]  frame_bits = '0;
    logic                in_frame = 1'b0;
    logic [PTR_W-1:0]    slot_ptr = '0;

    // Advance the receiver by one line sample; a finished byte goes to the parser.
    task automatic receive_line_sample(input logic level);
        t_result           res;
        logic [BYTE_W-1:0] rx_byte;
        logic              good;
        if (!rx_active) begin
            if (line_prev && !level) begin
                rx_active   = 1'b1;
                phase_count = first_delay_reg;
                bit_count   = '0;
                frame_bits  = '0;
            end
        end else if (phase_count > 1) begin
            phase_count = phase_count - 1'b1;
        end else begin
            frame_bits  = {level, frame_bits[FRAME_W-1:1]};
            bit_count   = bit_count + 1'b1;
            phase_count = bit_period_reg;
            if (bit_count >= FRAME_W) begin
                rx_active   = 1'b0;
                bit_count   = '0;
                phase_count = '0;
                rx_byte     = frame_bits[BYTE_W:1];
                good        = !frame_bits[0] && frame_bits[FRAME_W-1];
                res         = '0;
                res.byte_value    = rx_byte;
                res.framing_error = !good;
                if (good) begin
                    if (in_frame) begin
                        if (rx_byte >= CHR_ZERO && rx_byte <= CHR_NINE) begin
                            if (slot_ptr < TEXT_SLOTS) begin
                                res.digit_stored = 1'b1;
                                res.slot_written = slot_ptr[SLOT_W-1:0];
                                res.digit_value  = DIGIT_W'(rx_byte - CHR_ZERO);
                            end
                        end else if (rx_byte == CHR_COMMA) begin
                            if (slot_ptr < SLOT_CAP) slot_ptr = slot_ptr + 1'b1;
                        end else if (rx_byte == CHR_CLOSE) begin
                            in_frame = 1'b0;
                        end
                    end else if (rx_byte == CHR_OPEN) begin
                        slot_ptr = '0;
                        in_frame = 1'b1;
                    end
                end
                res.frame_open = in_frame;
                expected_bytes.push_back(res);
            end
        end
        line_prev = level;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Monitor: follow config writes and accepted samples, check every result.
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        t_result got;
        line_taken = i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BIT_PERIOD) bit_period_reg = i_cfg_wdata;
                else first_delay_reg = i_cfg_wdata;
            end
            if (line_taken) receive_line_sample(i_s_axis_tdata[0]);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[RESULT_W-1:0]);
                if (expected_bytes.size() == 0) begin
                    $error("result with none expected: byte_value %0h", got.byte_value);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("byte_value", want.byte_value, got.byte_value);
                    check_field("framing_error", want.framing_error, got.framing_error);
                    check_field("digit_stored", want.digit_stored, got.digit_stored);
                    check_field("slot_written", want.slot_written, got.slot_written);
                    check_field("digit_value", want.digit_value, got.digit_value);
                    check_field("frame_open", want.frame_open, got.frame_open);
                end
            end
        end
    end

    // Driver: one line sample per request, held until taken; random gaps on both sides.
    always @(negedge i_clk) begin : drive_lines
        logic       next_valid;
        logic [7:0] next_data;
        next_valid = i_s_axis_tvalid;
        next_data  = i_s_axis_tdata;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_s_axis_tvalid || line_taken) begin
            next_valid = 1'b0;
            if (line_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_valid = 1'b1;
                next_data  = {7'b0, line_queue.pop_front()};
            end
        end
        i_s_axis_tvalid <= next_valid;
        i_s_axis_tdata  <= next_data;
        i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic queue_idle(input int count);
        repeat (count) line_queue.push_back(1'b1);
    endtask

    // Lay out a 10-bit frame (start bit lowest) so each bit sits on its sample point.
    task automatic queue_serial_frame(input logic [FRAME_W-1:0] frame);
        int span;
        int t;
        int idx;
        span = gen_delay + (FRAME_W - 1) * gen_period;
        for (t = 0; t <= span; t++) begin
            idx = (t <= gen_delay) ? 0 : (t - gen_delay + gen_period - 1) / gen_period;
            line_queue.push_back((t == 0) ? 1'b0 : frame[idx]);
        end
    endtask

    function automatic logic [FRAME_W-1:0] good_frame(input logic [BYTE_W-1:0] b);
        return {1'b1, b, 1'b0};
    endfunction

    // Mostly well-formed parser traffic, with some bad frames and line glitches.
    task automatic queue_random_request();
        int                roll;
        logic [BYTE_W-1:0] any;
        roll = $urandom_range(0, 99);
        any  = BYTE_W'($urandom);
        queue_idle($urandom_range(0, 3));
        if (roll < 15) queue_serial_frame(good_frame(CHR_OPEN));
        else if (roll < 50) queue_serial_frame(good_frame(CHR_ZERO + 8'($urandom_range(0, 9))));
        else if (roll < 68) queue_serial_frame(good_frame(CHR_COMMA));
        else if (roll < 78) queue_serial_frame(good_frame(CHR_CLOSE));
        else if (roll < 88) queue_serial_frame(good_frame(any));
        else if (roll < 94) queue_serial_frame({1'($urandom), any, 1'b1});
        else if (roll < 97) queue_serial_frame({1'b0, any, 1'($urandom)});
        else begin
            repeat ($urandom_range(1, 3)) line_queue.push_back(1'b0);
            queue_idle(1);
        end
    endtask

    // Timing registers are written back to back while the receiver is idle.
    task automatic set_timing(input logic [TIMER_W-1:0] period, input logic [TIMER_W-1:0] delay);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BIT_PERIOD;
        i_cfg_wdata <= period;
        @(negedge i_clk);
        i_cfg_index <= CFG_FIRST_DELAY;
        i_cfg_wdata <= delay;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_period = (period == 0) ? 1 : period;
        gen_delay  = (delay == 0) ? 1 : delay;
    endtask

    // Send everything, idle the line until the receiver is done, collect all results.
    task automatic settle_line();
        int waited;
        while (line_queue.size() != 0 || i_s_axis_tvalid) @(negedge i_clk);
        while (rx_active) begin
            if (line_queue.size() == 0) line_queue.push_back(1'b1);
            @(negedge i_clk);
        end
        while (line_queue.size() != 0 || i_s_axis_tvalid) @(negedge i_clk);
        waited = 0;
        while (expected_bytes.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    initial begin : run_phases
        logic [FRAME_W-1:0] opening[$];
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at short timing: boundaries, slot saturation, bad frames.
        send_idle_pct = 31;
        recv_idle_pct = 75;
        set_timing(16'd1, 16'd1);
        opening = '{good_frame(8'h41), good_frame(CHR_OPEN), good_frame(CHR_ZERO),
                    good_frame(CHR_COMMA), good_frame(CHR_NINE), good_frame(8'h2f),
                    good_frame(8'h3a), good_frame(CHR_OPEN), good_frame(8'hff),
                    good_frame(8'h00), good_frame(CHR_COMMA), good_frame(CHR_COMMA),
                    good_frame(CHR_COMMA), good_frame(CHR_COMMA), good_frame(CHR_COMMA),
                    good_frame(CHR_COMMA), good_frame(CHR_COMMA), good_frame(8'h35),
                    good_frame(CHR_COMMA), good_frame(CHR_CLOSE), good_frame(8'h37),
                    {1'b1, CHR_OPEN, 1'b1}, {1'b0, CHR_OPEN, 1'b0},
                    good_frame(CHR_OPEN), good_frame(CHR_CLOSE)};
        foreach (opening[k]) begin
            queue_idle(2);
            queue_serial_frame(opening[k]);
        end
        settle_line();

        set_timing(16'd4, 16'd2);
        repeat (6) queue_random_request();
        settle_line();

        // Zero timing registers behave as one.
        send_idle_pct = 75;
        recv_idle_pct = 31;
        set_timing(16'd0, 16'd0);
        repeat (15) queue_random_request();
        settle_line();

        set_timing(16'd3, 16'd5);
        repeat (4) queue_random_request();
        settle_line();

        // Short timings with both sides always ready.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timing(16'd2, 16'd1);
        repeat (8) queue_random_request();
        settle_line();

        if (expected_bytes.size() != 0) begin
            $error("%0d results never arrived", expected_bytes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/urdfp_pkg.sv
src/urdfp_bit_rx.sv
src/urdfp_parser.sv
src/uart_rx_digit_frame_parser.sv
tb/sv/tb.sv
